@@ design/pwcpm_pkg.sv @@
// shared constants and types for the pulse width capture power meter
`timescale 1ns / 1ps
package pwcpm_pkg;

  localparam int NUM_CHANNELS_DEF = 2;

  localparam int TIME_W     = 24;
  localparam int WIDTH_W    = 32;
  localparam int POWER_W    = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_ADDR_W = 2;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 96;

  localparam logic [CFG_W-1:0] TIMER_PERIOD_RST = 24'd2000000;
  localparam logic [CFG_W-1:0] POWER_SCALE_RST  = 24'd8136000;
  localparam logic [CFG_W-1:0] POWER_LIMIT_RST  = 24'd1000000;

  // milliwatts per watt, applied to the scale before division
  localparam int MW_PER_W = 1000;

  // scale * 1000 stays below 2^34
  localparam int DIVIDEND_W = 34;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TIMER_PERIOD = 2'd0,
    CFG_POWER_SCALE  = 2'd1,
    CFG_POWER_LIMIT  = 2'd2
  } cfg_addr_t;

  typedef enum logic {
    ACT_EDGE = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

endpackage

@@ design/pulse_width_capture_power_meter_unit.sv @@
// top level of the pulse width capture power meter
`timescale 1ns / 1ps
// Two-channel pulse width meter fed by captured edge times and timer overflow ticks.
// Every input transaction gives exactly one output transaction: a snapshot of both
// widths, the channel 0 power in milliwatts and the wait flags after the update.
// A tick, an opening edge or a closing edge on channel 1 goes from acceptance straight to
// the result load; a closing edge on channel 0 passes accept, scale multiply, 34 steps of
// the bit-serial restoring divider, limit check and result load, or skips the divider
// and the limit check when the width is zero. A result still waiting in the output
// register holds the sequencer in its load step. Input is accepted whenever the
// sequencer is idle, even while an earlier result still waits in the output register.
// The user must write configuration through cfg_we / cfg_addr / cfg_wdata only while no
// transaction is in flight; the block itself does not enforce it.
module pulse_width_capture_power_meter_unit #(
  parameter int NUM_CHANNELS = pwcpm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [pwcpm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pwcpm_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [pwcpm_pkg::IN_TDATA_W-1:0]      in_tdata,   // capture_time[23:0]
  input  logic [pwcpm_pkg::IN_TUSER_W-1:0]      in_tuser,   // action[0], channel[1]
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // width_ch0[31:0], width_ch1[63:32], power_mw[87:64], wait_fall_ch0[88],
  // wait_fall_ch1[89], zero[95:90]
  output logic [pwcpm_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import pwcpm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] period_r, period_nxt;
  logic [CFG_W-1:0] scale_r, scale_nxt;
  logic [CFG_W-1:0] limit_r, limit_nxt;

  logic [NUM_CHANNELS-1:0]              phase_r, phase_nxt;
  logic [NUM_CHANNELS-1:0]              ovf_r, ovf_nxt;
  logic [NUM_CHANNELS-1:0][TIME_W-1:0]  start_r, start_nxt;
  logic [NUM_CHANNELS-1:0][WIDTH_W-1:0] width_r, width_nxt;
  logic [POWER_W-1:0]                   power_r, power_nxt;

  logic [DIVIDEND_W-1:0] dq_r, dq_nxt;
  logic [WIDTH_W:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic          in_action;
  logic          in_channel;
  logic [TIME_W-1:0] in_time;

  logic [WIDTH_W-1:0] w_new;
  logic [WIDTH_W:0]   rem_sh;
  logic               close_ch0;
  logic [WIDTH_W-1:0] snap_w0, snap_w1;
  logic               snap_wait0, snap_wait1;

  assign in_action  = in_tuser[0];
  assign in_channel = in_tuser[1];
  assign in_time    = in_tdata[TIME_W-1:0];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // result snapshot from the current state
  always_comb begin
    snap_w0    = width_r[0];
    snap_wait0 = phase_r[0];
    snap_w1    = '0;
    snap_wait1 = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (c == 1) begin
        snap_w1    = width_r[c];
        snap_wait1 = phase_r[c];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    scale_nxt     = scale_r;
    limit_nxt     = limit_r;
    phase_nxt     = phase_r;
    ovf_nxt       = ovf_r;
    start_nxt     = start_r;
    width_nxt     = width_r;
    power_nxt     = power_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    w_new         = '0;
    close_ch0     = 1'b0;
    rem_sh        = {rem_r[WIDTH_W-1:0], dq_r[DIVIDEND_W-1]};

    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TIMER_PERIOD: period_nxt = cfg_wdata;
        CFG_POWER_SCALE:  scale_nxt  = cfg_wdata;
        CFG_POWER_LIMIT:  limit_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_action == ACT_TICK) begin
            // overflow count runs 0,1 and wraps at the second tick
            for (int c = 0; c < NUM_CHANNELS; c++) begin
              if (ovf_r[c]) begin
                ovf_nxt[c] = 1'b0;
                if (c == 0) begin
                  power_nxt = '0;
                end
                if (phase_r[c]) begin
                  phase_nxt[c] = 1'b0;
                  width_nxt[c] = '0;
                end
              end else begin
                ovf_nxt[c] = 1'b1;
              end
            end
          end else begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
              if (c < 2 && in_channel == 1'(c)) begin
                if (!phase_r[c]) begin
                  start_nxt[c] = in_time;
                  phase_nxt[c] = 1'b1;
                  ovf_nxt[c]   = 1'b0;
                end else begin
                  w_new = WIDTH_W'(in_time)
                        + (ovf_r[c] ? WIDTH_W'(period_r) : '0)
                        - WIDTH_W'(start_r[c]);
                  width_nxt[c] = w_new;
                  phase_nxt[c] = 1'b0;
                  if (c == 0) begin
                    close_ch0 = 1'b1;
                  end
                end
              end
            end
          end
          state_nxt = close_ch0 ? S_MUL : S_EMIT;
        end
      end
      S_MUL: begin
        if (width_r[0] == '0) begin
          power_nxt = '0;
          state_nxt = S_EMIT;
        end else begin
          dq_nxt    = DIVIDEND_W'(scale_r) * DIVIDEND_W'(MW_PER_W);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // one quotient bit per cycle, shifted in behind the dividend
        if (rem_sh >= {1'b0, width_r[0]}) begin
          rem_nxt = rem_sh - {1'b0, width_r[0]};
          dq_nxt  = {dq_r[DIVIDEND_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          dq_nxt  = {dq_r[DIVIDEND_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        power_nxt = (dq_r > DIVIDEND_W'(limit_r)) ? '0 : dq_r[POWER_W-1:0];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, snap_wait1, snap_wait0, power_r, snap_w1, snap_w0};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= TIMER_PERIOD_RST;
      scale_r     <= POWER_SCALE_RST;
      limit_r     <= POWER_LIMIT_RST;
      phase_r     <= '0;
      ovf_r       <= '0;
      width_r     <= '0;
      power_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      scale_r     <= scale_nxt;
      limit_r     <= limit_nxt;
      phase_r     <= phase_nxt;
      ovf_r       <= ovf_nxt;
      width_r     <= width_nxt;
      power_r     <= power_nxt;
      out_valid_r <= out_valid_nxt;
    end
    start_r    <= start_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != S_IDLE)
    else $error("accepted transaction did not start processing");

  a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r < DIV_CNT_W'(DIVIDEND_W))
    else $error("divider step count overran");

  a_power_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> power_r <= limit_r)
    else $error("power above limit after division");

  a_remainder_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && cnt_r != '0 |-> rem_r < {1'b0, width_r[0]})
    else $error("divider remainder not reduced");
`endif

endmodule

@@ tb/sv/pwcpm_snapshot_checker.sv @@
// checker for the pulse width capture power meter: predicts every snapshot and compares
`timescale 1ns / 1ps
module pwcpm_snapshot_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [pwcpm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pwcpm_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                  in_tvalid,
  input  logic                                  in_tready,
  input  logic [pwcpm_pkg::IN_TDATA_W-1:0]      in_tdata,   // capture_time[23:0]
  input  logic [pwcpm_pkg::IN_TUSER_W-1:0]      in_tuser,   // action[0], channel[1]
  input  logic                                  out_tvalid,
  input  logic                                  out_tready,
  // width_ch0[31:0], width_ch1[63:32], power_mw[87:64], wait_fall_ch0[88],
  // wait_fall_ch1[89], zero[95:90]
  input  logic [pwcpm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output int                                    results_seen,
  output int                                    outstanding,
  output int                                    mismatches
);

  localparam int MILLI = 1000;

  typedef struct packed {
    logic [31:0] width_ch0;
    logic [31:0] width_ch1;
    logic [23:0] power_mw;
    logic        wait_fall_ch0;
    logic        wait_fall_ch1;
  } meter_snapshot_t;

  logic [23:0] period_q;
  logic [23:0] scale_q;
  logic [23:0] limit_q;

  logic        armed_q [2];
  logic [23:0] start_q [2];
  logic [1:0]  ovf_q   [2];
  logic [31:0] width_q [2];
  logic [23:0] power_q;

  meter_snapshot_t expected_snapshots[$];

  task automatic report(input string msg);
    if (mismatches < 100)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic clear_meter();
    period_q = pwcpm_pkg::TIMER_PERIOD_RST;
    scale_q  = pwcpm_pkg::POWER_SCALE_RST;
    limit_q  = pwcpm_pkg::POWER_LIMIT_RST;
    for (int c = 0; c < 2; c++) begin
      armed_q[c] = 1'b0;
      start_q[c] = '0;
      ovf_q[c]   = '0;
      width_q[c] = '0;
    end
    power_q = '0;
    expected_snapshots.delete();
  endtask

  // quotient formed wide so the limit test sees the full value
  function automatic logic [23:0] power_from_width(input logic [31:0] w);
    logic [63:0] q;
    if (w == 32'd0)
      return '0;
    q = (64'(scale_q) * 64'(MILLI)) / 64'(w);
    if (q > 64'(limit_q))
      return '0;
    return q[23:0];
  endfunction

  task automatic advance_meter(input pwcpm_pkg::action_t act, input logic ch,
                               input logic [23:0] t);
    logic [31:0]     w;
    meter_snapshot_t snap;
    if (act == pwcpm_pkg::ACT_EDGE) begin
      if (!armed_q[ch]) begin
        start_q[ch] = t;
        armed_q[ch] = 1'b1;
        ovf_q[ch]   = '0;
      end else begin
        w = 32'(t) + 32'(ovf_q[ch]) * 32'(period_q) - 32'(start_q[ch]);
        width_q[ch] = w;
        armed_q[ch] = 1'b0;
        if (ch == 1'b0)
          power_q = power_from_width(w);
      end
    end else begin
      for (int c = 0; c < 2; c++) begin
        ovf_q[c] = ovf_q[c] + 2'd1;
        // second overflow without a closing edge drops the pulse
        if (ovf_q[c] >= 2'd2) begin
          if (c == 0)
            power_q = '0;
          ovf_q[c] = '0;
          if (armed_q[c]) begin
            armed_q[c] = 1'b0;
            width_q[c] = '0;
          end
        end
      end
    end
    snap.width_ch0     = width_q[0];
    snap.width_ch1     = width_q[1];
    snap.power_mw      = power_q;
    snap.wait_fall_ch0 = armed_q[0];
    snap.wait_fall_ch1 = armed_q[1];
    expected_snapshots.push_back(snap);
  endtask

  task automatic compare_snapshot(input logic [pwcpm_pkg::OUT_TDATA_W-1:0] d);
    meter_snapshot_t exp_s;
    if (expected_snapshots.size() == 0) begin
      report($sformatf("result %h with nothing expected", d));
    end else begin
      exp_s = expected_snapshots.pop_front();
      if (d[31:0] !== exp_s.width_ch0)
        report($sformatf("width_ch0 got %0d expected %0d", d[31:0], exp_s.width_ch0));
      if (d[63:32] !== exp_s.width_ch1)
        report($sformatf("width_ch1 got %0d expected %0d", d[63:32], exp_s.width_ch1));
      if (d[87:64] !== exp_s.power_mw)
        report($sformatf("power_mw got %0d expected %0d", d[87:64], exp_s.power_mw));
      if (d[88] !== exp_s.wait_fall_ch0)
        report($sformatf("wait_fall_ch0 got %b expected %b", d[88], exp_s.wait_fall_ch0));
      if (d[89] !== exp_s.wait_fall_ch1)
        report($sformatf("wait_fall_ch1 got %b expected %b", d[89], exp_s.wait_fall_ch1));
      if (d[95:90] !== 6'd0)
        report($sformatf("padding bits got %b", d[95:90]));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_meter();
      mismatches   = 0;
      results_seen <= 0;
      outstanding  <= 0;
    end else begin
      if (cfg_we) begin
        case (pwcpm_pkg::cfg_addr_t'(cfg_addr))
          pwcpm_pkg::CFG_TIMER_PERIOD: period_q = cfg_wdata;
          pwcpm_pkg::CFG_POWER_SCALE:  scale_q  = cfg_wdata;
          pwcpm_pkg::CFG_POWER_LIMIT:  limit_q  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        advance_meter(pwcpm_pkg::action_t'(in_tuser[0]), in_tuser[1], in_tdata);
      if (out_tvalid && out_tready) begin
        compare_snapshot(out_tdata);
        results_seen <= results_seen + 1;
      end
      outstanding <= expected_snapshots.size();
    end
  end

endmodule

@@ tb/sv/tb_pulse_width_capture_power_meter_unit.sv @@
// testbench top: edge and tick stimulus, register settings and the verdict
`timescale 1ns / 1ps
module tb_pulse_width_capture_power_meter_unit;

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [pwcpm_pkg::CFG_ADDR_W-1:0]    cfg_addr = '0;
  logic [pwcpm_pkg::CFG_W-1:0]         cfg_wdata = '0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [pwcpm_pkg::IN_TDATA_W-1:0]    in_tdata = '0;   // capture_time[23:0]
  logic [pwcpm_pkg::IN_TUSER_W-1:0]    in_tuser = '0;   // action[0], channel[1]
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  // width_ch0[31:0], width_ch1[63:32], power_mw[87:64], wait_fall_ch0[88],
  // wait_fall_ch1[89], zero[95:90]
  logic [pwcpm_pkg::OUT_TDATA_W-1:0]   out_tdata;

  int   results_seen;
  int   outstanding;
  int   mismatches;
  int   sent = 0;
  logic steady = 1'b0;

  pulse_width_capture_power_meter_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  pwcpm_snapshot_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .results_seen (results_seen),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk)
    out_tready <= steady || ($urandom_range(99) >= 38);

  task automatic send_item(input pwcpm_pkg::action_t act, input logic ch,
                           input logic [23:0] t);
    while (!steady && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    in_tuser  <= {ch, act};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    sent++;
  endtask

  // tick carries random channel and time bits, which the block ignores
  task automatic send_tick();
    send_item(pwcpm_pkg::ACT_TICK, 1'($urandom), 24'($urandom));
  endtask

  task automatic send_edge(input logic ch, input logic [23:0] t);
    send_item(pwcpm_pkg::ACT_EDGE, ch, t);
  endtask

  task automatic set_reg(input pwcpm_pkg::cfg_addr_t a, input logic [23:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (results_seen != sent)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [23:0] pulse_span();
    case ($urandom_range(3))
      0:       return 24'($urandom_range(16));
      1:       return 24'($urandom_range(20000));
      2:       return 24'($urandom_range(3000000));
      default: return 24'($urandom);
    endcase
  endfunction

  // opening edge, zero to two overflows, maybe an edge on the other channel, closing edge
  task automatic measure_pulse(input logic ch);
    logic [23:0] t0;
    int          r;
    int          ticks;
    t0 = 24'($urandom);
    send_edge(ch, t0);
    r = $urandom_range(9);
    ticks = (r < 6) ? 0 : (r < 9) ? 1 : 2;
    repeat (ticks) send_tick();
    if ($urandom_range(3) == 0)
      send_edge(~ch, 24'($urandom));
    send_edge(ch, t0 + pulse_span());
  endtask

  logic [23:0] period_set [6];
  logic [23:0] scale_set  [6];
  logic [23:0] limit_set  [6];

  initial begin
    int r;
    int goal;
    period_set = '{24'd1, 24'hFFFFFF, 24'd0, 24'd2000000, 24'd0, 24'd0};
    scale_set  = '{24'hFFFFFF, 24'd1, 24'd8136000, 24'd8136000, 24'd0, 24'd0};
    limit_set  = '{24'hFFFFFF, 24'd0, 24'd1000000, 24'd1000000, 24'd0, 24'd0};
    for (int p = 4; p < 6; p++) begin
      period_set[p] = 24'($urandom_range(1, 24'hFFFFFF));
      scale_set[p]  = 24'($urandom_range(1, 24'hFFFFFF));
      limit_set[p]  = 24'($urandom);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset register values
    send_tick();
    send_edge(1'b0, 24'd0);
    send_edge(1'b0, 24'd0);          // zero width
    send_edge(1'b0, 24'd100);
    send_edge(1'b0, 24'd200);        // power far above limit
    send_edge(1'b0, 24'd0);
    send_edge(1'b0, 24'd8136);       // power exactly at limit
    send_edge(1'b0, 24'd0);
    send_edge(1'b0, 24'd8135);       // just over limit
    send_edge(1'b0, 24'd1000);
    send_edge(1'b0, 24'd1001000);
    send_tick();
    send_tick();                     // second overflow clears power
    send_edge(1'b1, 24'd5);
    send_tick();
    send_tick();                     // channel 1 pulse abandoned
    send_edge(1'b0, 24'hFFFFFF);
    send_tick();
    send_edge(1'b0, 24'd0);          // close across one overflow
    send_edge(1'b1, 24'hFFFFFF);
    send_edge(1'b1, 24'd0);          // width wraps
    send_item(pwcpm_pkg::ACT_TICK, 1'b1, 24'hFFFFFF);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_reg(pwcpm_pkg::CFG_TIMER_PERIOD, period_set[p]);
      set_reg(pwcpm_pkg::CFG_POWER_SCALE, scale_set[p]);
      set_reg(pwcpm_pkg::CFG_POWER_LIMIT, limit_set[p]);
      cfg_we <= 1'b0;
      steady = (p == 3);
      goal = sent + 185;
      while (sent < goal) begin
        r = $urandom_range(99);
        if (r < 70)
          measure_pulse(1'($urandom));
        else if (r < 85)
          send_tick();
        else
          send_edge(1'($urandom), 24'($urandom));
      end
      drain();
    end
    steady = 1'b0;

    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ pulse_width_capture_power_meter_unit.f @@
design/pwcpm_pkg.sv
design/pulse_width_capture_power_meter_unit.sv
tb/sv/pwcpm_snapshot_checker.sv
tb/sv/tb_pulse_width_capture_power_meter_unit.sv
